[rtl/cubic_bspline_trajectory_eval_core_macros.svh]
// Assertion macros shared by the trajectory evaluator RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef CUBIC_BSPLINE_TRAJECTORY_EVAL_CORE_MACROS_SVH
`define CUBIC_BSPLINE_TRAJECTORY_EVAL_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CBTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trajectory evaluator assertion failed");

// Check that cons holds in the cycle after ante.
`define CBTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trajectory evaluator assertion failed");

`endif

[rtl/cbte_pkg.sv]
// Shared types, constants and the divide-by-six helper of the trajectory evaluator.
// No dependencies.
package cbte_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF = 32;

  localparam int unsigned IN_TDATA_W  = 160;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 288;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam logic [CFG_ADDR_W-1:0] REG_TIME_ORIGIN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_INTERVAL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_POINT_COUNT  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [28:0] INV_RESET     = 29'd167772160;
  localparam logic [63:0] SLOW_SQ_LIMIT = 64'd429496;
  localparam logic [28:0] DIV6_MUL      = 29'd357913942;
  localparam int unsigned DIV6_SHIFT    = 31;
  localparam int unsigned LANE_LAT      = 6;

  typedef logic signed [26:0] weight_t;

  typedef struct packed {
    weight_t b0;
    weight_t b1;
    weight_t b2;
    weight_t d0;
    weight_t d1;
    weight_t d2;
    weight_t dd0;
    weight_t dd1;
    weight_t dd2;
  } weights_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } ctrl_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic [63:0]        sq;
  } lane_res_t;

  // truncating signed divide by six, valid for |x| < 2^28
  function automatic weight_t div6(input logic signed [28:0] x);
    logic [27:0] mag;
    logic [56:0] prod;
    logic [25:0] q;
    mag  = x[28] ? 28'(-x) : x[27:0];
    prod = 57'(mag) * 57'(DIV6_MUL);
    q    = prod[DIV6_SHIFT+25:DIV6_SHIFT];
    return x[28] ? -weight_t'({1'b0, q}) : weight_t'({1'b0, q});
  endfunction

endpackage

[rtl/cbte_bank.sv]
// One control point memory bank: a write port and a registered read port.
// Depends on nothing; instantiated four times by the top level.
module cbte_bank #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 96
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/cbte_lane.sv]
// One axis lane: basis blend, time scaling and saturation of position, velocity, acceleration.
// Depends on cbte_pkg.
module cbte_lane #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] p0,
  input  logic signed [COORD_BITS:0]   e1,
  input  logic signed [COORD_BITS:0]   e2,
  input  logic signed [COORD_BITS:0]   e3,
  input  cbte_pkg::weights_t           w,
  input  logic [28:0]                  inv,
  output cbte_pkg::lane_res_t          res
);
  import cbte_pkg::*;

  localparam int unsigned EW   = COORD_BITS + 1;
  localparam int unsigned PW   = EW + 27;
  localparam int unsigned SW   = COORD_BITS + 31;
  localparam int unsigned VW   = SW - 24;
  localparam int unsigned PHW  = VW - 16 + 30;
  localparam int unsigned V2W  = VW + 30;
  localparam int unsigned A2W  = V2W - 24;
  localparam int unsigned PH2W = A2W - 16 + 30;
  localparam int unsigned ACW  = A2W + 30;
  localparam int unsigned SATW = ACW - 24;

  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] x);
    logic hi_one;
    logic hi_zero;
    hi_one  = &x[SATW-1:31];
    hi_zero = ~|x[SATW-1:31];
    if (hi_one || hi_zero) begin
      return x[31:0];
    end
    return x[SATW-1] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  logic signed [30:0] inv_s;
  assign inv_s = $signed({2'b0, inv});

  logic signed [PW-1:0] mb0_r, mb1_r, mb2_r, md0_r, md1_r, md2_r, ma0_r, ma1_r, ma2_r;
  logic signed [COORD_BITS-1:0] p0_1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mb0_r  <= PW'(e1) * PW'(w.b0);
      mb1_r  <= PW'(e2) * PW'(w.b1);
      mb2_r  <= PW'(e3) * PW'(w.b2);
      md0_r  <= PW'(e1) * PW'(w.d0);
      md1_r  <= PW'(e2) * PW'(w.d1);
      md2_r  <= PW'(e3) * PW'(w.d2);
      ma0_r  <= PW'(e1) * PW'(w.dd0);
      ma1_r  <= PW'(e2) * PW'(w.dd1);
      ma2_r  <= PW'(e3) * PW'(w.dd2);
      p0_1_r <= p0;
    end
  end

  logic signed [SW-1:0] psum, vsum, asum;
  assign psum = (SW'(p0_1_r) <<< 24) + SW'(mb0_r) + SW'(mb1_r) + SW'(mb2_r);
  assign vsum = SW'(md0_r) + SW'(md1_r) + SW'(md2_r);
  assign asum = SW'(ma0_r) + SW'(ma1_r) + SW'(ma2_r);

  logic signed [31:0]   pos_2_r;
  logic signed [VW-1:0] v_2_r, a_2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_2_r <= sat32(SATW'($signed(psum[SW-1:24])));
      v_2_r   <= $signed(vsum[SW-1:24]);
      a_2_r   <= $signed(asum[SW-1:24]);
    end
  end

  logic signed [PHW-1:0] vph_3_r, aph_3_r;
  logic [44:0]           vpl_3_r, apl_3_r;
  logic signed [31:0]    pos_3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vph_3_r <= PHW'($signed(v_2_r[VW-1:16])) * PHW'(inv_s);
      aph_3_r <= PHW'($signed(a_2_r[VW-1:16])) * PHW'(inv_s);
      vpl_3_r <= 45'(v_2_r[15:0]) * 45'(inv);
      apl_3_r <= 45'(a_2_r[15:0]) * 45'(inv);
      pos_3_r <= pos_2_r;
    end
  end

  logic signed [V2W-1:0] vs4, as4;
  assign vs4 = (V2W'(vph_3_r) <<< 16) + V2W'($signed({1'b0, vpl_3_r}));
  assign as4 = (V2W'(aph_3_r) <<< 16) + V2W'($signed({1'b0, apl_3_r}));

  logic signed [31:0]    pos_4_r, vel_4_r;
  logic signed [A2W-1:0] a2_4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_4_r <= pos_3_r;
      vel_4_r <= sat32(SATW'($signed(vs4[V2W-1:24])));
      a2_4_r  <= $signed(as4[V2W-1:24]);
    end
  end

  logic signed [PH2W-1:0] a2h_5_r;
  logic [44:0]            a2l_5_r;
  logic signed [31:0]     pos_5_r, vel_5_r;
  logic signed [63:0]     sq_5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a2h_5_r <= PH2W'($signed(a2_4_r[A2W-1:16])) * PH2W'(inv_s);
      a2l_5_r <= 45'(a2_4_r[15:0]) * 45'(inv);
      pos_5_r <= pos_4_r;
      vel_5_r <= vel_4_r;
      sq_5_r  <= 64'(vel_4_r) * 64'(vel_4_r);
    end
  end

  logic signed [ACW-1:0] accsum;
  assign accsum = (ACW'(a2h_5_r) <<< 16) + ACW'($signed({1'b0, a2l_5_r}));

  lane_res_t res_6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_6_r.pos <= pos_5_r;
      res_6_r.vel <= vel_5_r;
      res_6_r.acc <= sat32($signed(accsum[ACW-1:24]));
      res_6_r.sq  <= sq_5_r;
    end
  end

  assign res = res_6_r;

endmodule

[rtl/cbte_merge.sv]
// Merge of the three axis lanes: speed check, zeroing of rejected queries, output register and skid.
// Depends on cbte_pkg and the assertion macro header.
`include "cubic_bspline_trajectory_eval_core_macros.svh"
module cbte_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cbte_pkg::ctrl_t                      ctrl,
  input  cbte_pkg::lane_res_t                  rx,
  input  cbte_pkg::lane_res_t                  ry,
  input  cbte_pkg::lane_res_t                  rz,
  output logic                                 en,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
  output logic [cbte_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // ok, too_slow
  output logic [cbte_pkg::OUT_TUSER_W-1:0]     out_tuser
);
  import cbte_pkg::*;

  logic [63:0]            sumsq;
  logic                   slow;
  logic [OUT_TDATA_W-1:0] new_data;
  logic [OUT_TUSER_W-1:0] new_user;
  logic                   push;

  assign sumsq = rx.sq + ry.sq + rz.sq;
  assign slow  = (sumsq <= SLOW_SQ_LIMIT);

  always_comb begin
    if (ctrl.ok) begin
      new_data = {rz.acc, ry.acc, rx.acc, rz.vel, ry.vel, rx.vel, rz.pos, ry.pos, rx.pos};
      new_user = {slow, 1'b1};
    end else begin
      new_data = '0;
      new_user = '0;
    end
  end

  logic                   outv_r, outv_nxt;
  logic                   skv_r, skv_nxt;
  logic [OUT_TDATA_W-1:0] outd_r, outd_nxt, skd_r;
  logic [OUT_TUSER_W-1:0] outu_r, outu_nxt, sku_r;
  logic                   load_skid;

  assign en   = !skv_r;
  assign push = en && ctrl.valid;

  always_comb begin
    outv_nxt  = outv_r;
    skv_nxt   = skv_r;
    outd_nxt  = outd_r;
    outu_nxt  = outu_r;
    load_skid = 1'b0;
    if (skv_r) begin
      if (out_tready) begin
        outd_nxt = skd_r;
        outu_nxt = sku_r;
        skv_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!outv_r || out_tready) begin
        outd_nxt = new_data;
        outu_nxt = new_user;
        outv_nxt = 1'b1;
      end else begin
        load_skid = 1'b1;
        skv_nxt   = 1'b1;
      end
    end else if (out_tready) begin
      outv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
      skv_r  <= 1'b0;
    end else begin
      outv_r <= outv_nxt;
      skv_r  <= skv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outd_r <= outd_nxt;
    outu_r <= outu_nxt;
    if (load_skid) begin
      skd_r <= new_data;
      sku_r <= new_user;
    end
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = outd_r;
  assign out_tuser  = outu_r;

  `CBTE_ASSERT_IMP(a_skid_needs_out, skv_r, outv_r)
  `CBTE_ASSERT_NXT(a_skid_holds, skv_r && !out_tready, skv_r && $stable(skd_r))
  `CBTE_ASSERT_IMP(a_reject_zero, outv_r && !outu_r[0], outd_r == '0 && !outu_r[1])

endmodule

[rtl/cubic_bspline_trajectory_eval_core.sv]
// Uniform cubic B-spline trajectory evaluator. A load transaction (tuser 0) writes one
// control point; an evaluate transaction (tuser 1) returns position, velocity and
// acceleration on three axes plus ok and too_slow flags. The block takes one transaction
// every cycle while in_tready is high (it drops while the output skid is full); an evaluate
// result passes through segment mapping, bank read and basis weights, then the axis lanes,
// then the output register. The four control point banks (index modulo four) are each read
// once per enabled cycle, so the four points of a segment come out together. Loads produce
// no result and take effect in order with evaluates.
module cubic_bspline_trajectory_eval_core #(
  parameter int unsigned MAX_POINTS = cbte_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = cbte_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // point_index, coord_x, coord_y, coord_z, query_time
  input  logic [cbte_pkg::IN_TDATA_W-1:0]      in_tdata,
  // opcode
  input  logic [cbte_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
  output logic [cbte_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // ok, too_slow
  output logic [cbte_pkg::OUT_TUSER_W-1:0]     out_tuser,
  input  logic                                 cfg_we,
  input  logic [cbte_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [cbte_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cbte_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned CW3   = 3 * CB;
  localparam int unsigned IW    = $clog2(MAX_POINTS);
  localparam int unsigned DEPTH = (MAX_POINTS + 3) / 4;
  localparam int unsigned BAW   = (IW > 2) ? IW - 2 : 1;

  function automatic logic [CB-1:0] coord_fit(input logic [31:0] c);
    logic signed [63:0] c64;
    c64 = 64'($signed(c));
    return c64[CB-1:0];
  endfunction

  logic        en;
  logic [47:0] origin_r;
  logic [28:0] inv_r;
  logic [10:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      inv_r    <= INV_RESET;
      cnt_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TIME_ORIGIN:  origin_r <= cfg_wdata;
        REG_INV_INTERVAL: inv_r    <= cfg_wdata[28:0];
        REG_POINT_COUNT:  cnt_r    <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign in_tready = en;

  // stage 1: capture, time offset
  logic           s1_v_r, s1_eval_r, s1_neg_r;
  logic [9:0]     s1_idx_r;
  logic [CW3-1:0] s1_c_r;
  logic [47:0]    s1_d_r;
  logic [47:0]    qt;

  assign qt = in_tdata[153:106];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_eval_r <= (in_tuser[0] == OP_EVAL);
      s1_idx_r  <= in_tdata[9:0];
      s1_c_r    <= {coord_fit(in_tdata[105:74]), coord_fit(in_tdata[73:42]),
                    coord_fit(in_tdata[41:10])};
      s1_neg_r  <= (qt < origin_r);
      s1_d_r    <= qt - origin_r;
    end
  end

  // stage 2: scale by inverse interval
  logic           s2_v_r, s2_eval_r, s2_neg_r;
  logic [9:0]     s2_idx_r;
  logic [CW3-1:0] s2_c_r;
  logic [52:0]    s2_mh_r, s2_ml_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_eval_r <= s1_eval_r;
      s2_neg_r  <= s1_neg_r;
      s2_idx_r  <= s1_idx_r;
      s2_c_r    <= s1_c_r;
      s2_mh_r   <= 53'(s1_d_r[47:24]) * 53'(inv_r);
      s2_ml_r   <= 53'(s1_d_r[23:0]) * 53'(inv_r);
    end
  end

  // stage 3: segment index, fraction, range check
  logic [53:0] seg;
  logic [29:0] seg_k;
  logic [31:0] cnt_c;
  logic        seg_inr;

  assign seg     = 54'(s2_mh_r) + 54'(s2_ml_r[52:24]);
  assign seg_k   = seg[53:24];
  assign cnt_c   = (32'(cnt_r) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : 32'(cnt_r);
  assign seg_inr = !s2_neg_r && (seg_k != 30'd0) && ((32'(seg_k) + 32'd3) <= cnt_c);

  logic           s3_v_r, s3_eval_r, s3_inr_r;
  logic [9:0]     s3_idx_r;
  logic [CW3-1:0] s3_c_r;
  logic [23:0]    s3_n_r;
  logic [IW-1:0]  s3_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_eval_r <= s2_eval_r;
      s3_inr_r  <= seg_inr;
      s3_idx_r  <= s2_idx_r;
      s3_c_r    <= s2_c_r;
      s3_n_r    <= seg[23:0];
      s3_base_r <= IW'(seg_k - 30'd1);
    end
  end

  // stage 4: bank write or read, u squared
  logic          load_ok;
  logic [IW-1:0] lidx;
  logic [CW3-1:0] rd [4];

  assign load_ok = s3_v_r && !s3_eval_r && (32'(s3_idx_r) < 32'(MAX_POINTS));
  assign lidx    = IW'(s3_idx_r);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]     boff;
    logic [IW:0]    jb;
    logic [BAW-1:0] raddr;
    logic [BAW-1:0] waddr;
    assign boff  = 2'(b) - s3_base_r[1:0];
    assign jb    = (IW + 1)'(s3_base_r) + (IW + 1)'(boff);
    assign raddr = BAW'(jb >> 2);
    assign waddr = BAW'(lidx >> 2);

    cbte_bank #(
      .DEPTH (DEPTH),
      .AW    (BAW),
      .DW    (CW3)
    ) u_bank (
      .clk   (clk),
      .en    (en),
      .we    (load_ok && (lidx[1:0] == 2'(b))),
      .waddr (waddr),
      .wdata (s3_c_r),
      .raddr (raddr),
      .rdata (rd[b])
    );
  end

  logic        s4_v_r, s4_ok_r;
  logic [23:0] s4_n_r, s4_u2_r;
  logic [1:0]  s4_rot_r;
  logic [47:0] nn;

  assign nn = 48'(s3_n_r) * 48'(s3_n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r && s3_eval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ok_r  <= s3_inr_r;
      s4_n_r   <= s3_n_r;
      s4_u2_r  <= nn[47:24];
      s4_rot_r <= s3_base_r[1:0];
    end
  end

  // stage 5: order the four points, differences, u cubed
  logic signed [CB-1:0] s5_p0_r [3];
  logic signed [CB:0]   s5_e1_r [3], s5_e2_r [3], s5_e3_r [3];
  logic                 s5_v_r, s5_ok_r;
  logic [23:0]          s5_n_r, s5_u2_r, s5_u3_r;
  logic [47:0]          un;

  assign un = 48'(s4_u2_r) * 48'(s4_n_r);

  for (genvar a = 0; a < 3; a++) begin : g_diff
    logic signed [CB-1:0] pt [4];
    for (genvar i = 0; i < 4; i++) begin : g_pt
      assign pt[i] = $signed(rd[2'(s4_rot_r + 2'(i))][a*CB +: CB]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s5_p0_r[a] <= pt[0];
        s5_e1_r[a] <= (CB + 1)'(pt[1]) - (CB + 1)'(pt[0]);
        s5_e2_r[a] <= (CB + 1)'(pt[2]) - (CB + 1)'(pt[1]);
        s5_e3_r[a] <= (CB + 1)'(pt[3]) - (CB + 1)'(pt[2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ok_r <= s4_ok_r;
      s5_n_r  <= s4_n_r;
      s5_u2_r <= s4_u2_r;
      s5_u3_r <= un[47:24];
    end
  end

  // stage 6: weight numerators
  localparam logic signed [28:0] ONE = 29'sd16777216;
  logic signed [28:0] n29, u229, u329;
  assign n29  = $signed({5'b0, s5_n_r});
  assign u229 = $signed({5'b0, s5_u2_r});
  assign u329 = $signed({5'b0, s5_u3_r});

  logic signed [28:0] s6_b0n_r, s6_b1n_r, s6_b2n_r, s6_d0n_r, s6_d1n_r, s6_d2n_r;
  weight_t            s6_dd0_r, s6_dd1_r, s6_dd2_r;
  logic signed [CB-1:0] s6_p0_r [3];
  logic signed [CB:0]   s6_e1_r [3], s6_e2_r [3], s6_e3_r [3];
  logic                 s6_v_r, s6_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ok_r  <= s5_ok_r;
      s6_b0n_r <= 29'sd5 * ONE + 29'sd3 * n29 - 29'sd3 * u229 + u329;
      s6_b1n_r <= ONE + 29'sd3 * n29 + 29'sd3 * u229 - 29'sd2 * u329;
      s6_b2n_r <= u329;
      s6_d0n_r <= 29'sd3 * ONE - 29'sd6 * n29 + 29'sd3 * u229;
      s6_d1n_r <= 29'sd3 * ONE + 29'sd6 * n29 - 29'sd6 * u229;
      s6_d2n_r <= 29'sd3 * u229;
      s6_dd0_r <= 27'(n29 - ONE);
      s6_dd1_r <= 27'(ONE - 29'sd2 * n29);
      s6_dd2_r <= 27'(n29);
      s6_p0_r  <= s5_p0_r;
      s6_e1_r  <= s5_e1_r;
      s6_e2_r  <= s5_e2_r;
      s6_e3_r  <= s5_e3_r;
    end
  end

  // stage 7: divide by six
  weights_t             s7_w_r;
  logic signed [CB-1:0] s7_p0_r [3];
  logic signed [CB:0]   s7_e1_r [3], s7_e2_r [3], s7_e3_r [3];
  logic                 s7_v_r, s7_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_ok_r    <= s6_ok_r;
      s7_w_r.b0  <= div6(s6_b0n_r);
      s7_w_r.b1  <= div6(s6_b1n_r);
      s7_w_r.b2  <= div6(s6_b2n_r);
      s7_w_r.d0  <= div6(s6_d0n_r);
      s7_w_r.d1  <= div6(s6_d1n_r);
      s7_w_r.d2  <= div6(s6_d2n_r);
      s7_w_r.dd0 <= s6_dd0_r;
      s7_w_r.dd1 <= s6_dd1_r;
      s7_w_r.dd2 <= s6_dd2_r;
      s7_p0_r    <= s6_p0_r;
      s7_e1_r    <= s6_e1_r;
      s7_e2_r    <= s6_e2_r;
      s7_e3_r    <= s6_e3_r;
    end
  end

  // axis lanes
  lane_res_t lres [3];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    cbte_lane #(
      .COORD_BITS (CB)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .p0  (s7_p0_r[a]),
      .e1  (s7_e1_r[a]),
      .e2  (s7_e2_r[a]),
      .e3  (s7_e3_r[a]),
      .w   (s7_w_r),
      .inv (inv_r),
      .res (lres[a])
    );
  end

  // control delay matching the lanes
  ctrl_t dl_r [LANE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        dl_r[i] <= '0;
      end
    end else if (en) begin
      dl_r[0] <= '{valid: s7_v_r, ok: s7_ok_r};
      for (int i = 1; i < LANE_LAT; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  cbte_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (dl_r[LANE_LAT-1]),
    .rx         (lres[0]),
    .ry         (lres[1]),
    .rz         (lres[2]),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
